/* src/es_descriptor_byte_parser_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef ES_DESCRIPTOR_BYTE_PARSER_CORE_DEFINES_SVH
`define ES_DESCRIPTOR_BYTE_PARSER_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define ESDP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled result keeps the given field unchanged in the next cycle.
`define ESDP_ASSERT_STALL(lbl, clk, rst_n, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> $stable(sig)) \
    else $error("result field changed while stalled");

`endif

/* src/esdp_pkg.sv */
package esdp_pkg;

  // Field widths
  localparam int unsigned LEN_W = 28;

  // Descriptor tags
  localparam logic [7:0] TAG_ES  = 8'h03;
  localparam logic [7:0] TAG_DEC = 8'h04;
  localparam logic [7:0] TAG_DSI = 8'h05;

  // Variable-length size field: 7 payload bits, bit 7 continues
  localparam logic [7:0] LEN_PAYLOAD_MASK = 8'h7F;
  localparam int unsigned LEN_CONT_BIT    = 7;

  localparam logic [LEN_W-1:0] MIN_ES_LEN  = LEN_W'(20);
  localparam logic [LEN_W-1:0] MIN_DEC_LEN = LEN_W'(15);
  localparam logic [LEN_W-1:0] ES_SKIP     = LEN_W'(3);
  localparam logic [LEN_W-1:0] OTHER_SKIP  = LEN_W'(2);

  // Byte counts of multi-byte fields
  localparam logic [2:0] MAX_LEN_BYTES = 3'd4;
  localparam logic [2:0] FLAG_BYTES    = 3'd3;
  localparam logic [2:0] BUF_BYTES     = 3'd3;
  localparam logic [2:0] RATE_BYTES    = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_VER,
    PH_FLAGS,
    PH_TAG1,
    PH_LEN1,
    PH_SKIP,
    PH_TAG2,
    PH_LEN2,
    PH_OBJ,
    PH_STREAM,
    PH_BUF,
    PH_MAX,
    PH_AVG,
    PH_TAG3,
    PH_LEN3,
    PH_CFG,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef enum logic [2:0] {
    ST_CONSUMED = 3'd0,
    ST_CFG      = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_ERROR    = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       config_byte;
    logic [7:0]       object_type;
    logic [7:0]       stream_type;
    logic [23:0]      buffer_size;
    logic [31:0]      max_bitrate;
    logic [31:0]      avg_bitrate;
    logic [LEN_W-1:0] config_length;
    logic [7:0]       version;
    logic [23:0]      flags;
  } result_t;

endpackage

/* src/esdp_if.sv */
// Byte input channel
interface esdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

// Result channel
interface esdp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  config_byte;
  logic [7:0]  object_type;
  logic [7:0]  stream_type;
  logic [23:0] buffer_size;
  logic [31:0] max_bitrate;
  logic [31:0] avg_bitrate;
  logic [27:0] config_length;
  logic [7:0]  version;
  logic [23:0] flags;

  modport source (
    output valid, output status, output config_byte, output object_type,
    output stream_type, output buffer_size, output max_bitrate, output avg_bitrate,
    output config_length, output version, output flags, input ready
  );
  modport sink (
    input valid, input status, input config_byte, input object_type,
    input stream_type, input buffer_size, input max_bitrate, input avg_bitrate,
    input config_length, input version, input flags, output ready
  );
endinterface

/* src/esdp_fsm.sv */
module esdp_fsm
  import esdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] data_byte,
  input  logic       start_req,
  output result_t    result
);

  phase_t           phase_r, phase_nxt, cur_phase;
  logic [2:0]       byte_count_r, byte_count_nxt, cur_byte_count;
  logic [LEN_W-1:0] length_accum_r, length_accum_nxt, cur_length_accum;
  logic [LEN_W-1:0] remaining_r, remaining_nxt, cur_remaining;
  logic [7:0]       object_r, object_nxt, cur_object;
  logic [7:0]       stream_r, stream_nxt, cur_stream;
  logic [23:0]      bufsize_r, bufsize_nxt, cur_bufsize;
  logic [31:0]      maxrate_r, maxrate_nxt, cur_maxrate;
  logic [31:0]      avgrate_r, avgrate_nxt, cur_avgrate;
  logic [LEN_W-1:0] cfglen_r, cfglen_nxt, cur_cfglen;
  logic [7:0]       version_r, version_nxt, cur_version;
  logic [23:0]      flags_r, flags_nxt, cur_flags;

  logic [LEN_W-1:0] len_shift;
  logic [LEN_W-1:0] rem_dec;
  logic [2:0]       count_inc;
  logic             len_done;
  status_t          status_s;
  logic [7:0]       cfg_byte_s;

  // A start byte clears the parse before it is decoded
  always_comb begin
    if (start_req) begin
      cur_phase        = PH_VER;
      cur_byte_count   = '0;
      cur_length_accum = '0;
      cur_remaining    = '0;
      cur_object       = '0;
      cur_stream       = '0;
      cur_bufsize      = '0;
      cur_maxrate      = '0;
      cur_avgrate      = '0;
      cur_cfglen       = '0;
      cur_version      = '0;
      cur_flags        = '0;
    end else begin
      cur_phase        = phase_r;
      cur_byte_count   = byte_count_r;
      cur_length_accum = length_accum_r;
      cur_remaining    = remaining_r;
      cur_object       = object_r;
      cur_stream       = stream_r;
      cur_bufsize      = bufsize_r;
      cur_maxrate      = maxrate_r;
      cur_avgrate      = avgrate_r;
      cur_cfglen       = cfglen_r;
      cur_version      = version_r;
      cur_flags        = flags_r;
    end
  end

  // Shared helpers: size accumulate, byte counter, skip counter
  assign len_shift = {cur_length_accum[LEN_W-8:0], data_byte[6:0] & LEN_PAYLOAD_MASK[6:0]};
  assign count_inc = cur_byte_count + 3'd1;
  assign len_done  = !data_byte[LEN_CONT_BIT] || (count_inc >= MAX_LEN_BYTES);
  assign rem_dec   = (cur_remaining != '0) ? (cur_remaining - LEN_W'(1)) : '0;

  // Next state and result for one byte
  always_comb begin
    phase_nxt        = cur_phase;
    byte_count_nxt   = cur_byte_count;
    length_accum_nxt = cur_length_accum;
    remaining_nxt    = cur_remaining;
    object_nxt       = cur_object;
    stream_nxt       = cur_stream;
    bufsize_nxt      = cur_bufsize;
    maxrate_nxt      = cur_maxrate;
    avgrate_nxt      = cur_avgrate;
    cfglen_nxt       = cur_cfglen;
    version_nxt      = cur_version;
    flags_nxt        = cur_flags;
    status_s         = ST_CONSUMED;
    cfg_byte_s       = '0;

    unique case (cur_phase)
      PH_VER: begin
        version_nxt    = data_byte;
        byte_count_nxt = '0;
        phase_nxt      = PH_FLAGS;
      end
      PH_FLAGS: begin
        flags_nxt      = {cur_flags[15:0], data_byte};
        byte_count_nxt = count_inc;
        if (count_inc >= FLAG_BYTES) phase_nxt = PH_TAG1;
      end
      PH_TAG1: begin
        if (data_byte == TAG_ES) begin
          phase_nxt        = PH_LEN1;
          byte_count_nxt   = '0;
          length_accum_nxt = '0;
        end else begin
          remaining_nxt = OTHER_SKIP;
          phase_nxt     = PH_SKIP;
        end
      end
      PH_LEN1: begin
        length_accum_nxt = len_shift;
        byte_count_nxt   = count_inc;
        if (len_done) begin
          if (len_shift < MIN_ES_LEN) begin
            status_s  = ST_ERROR;
            phase_nxt = PH_ERR;
          end else begin
            remaining_nxt = ES_SKIP;
            phase_nxt     = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        remaining_nxt = rem_dec;
        if (rem_dec == '0) phase_nxt = PH_TAG2;
      end
      PH_TAG2: begin
        if (data_byte != TAG_DEC) begin
          status_s  = ST_ERROR;
          phase_nxt = PH_ERR;
        end else begin
          phase_nxt        = PH_LEN2;
          byte_count_nxt   = '0;
          length_accum_nxt = '0;
        end
      end
      PH_LEN2: begin
        length_accum_nxt = len_shift;
        byte_count_nxt   = count_inc;
        if (len_done) begin
          if (len_shift < MIN_DEC_LEN) begin
            status_s  = ST_ERROR;
            phase_nxt = PH_ERR;
          end else begin
            phase_nxt = PH_OBJ;
          end
        end
      end
      PH_OBJ: begin
        object_nxt = data_byte;
        phase_nxt  = PH_STREAM;
      end
      PH_STREAM: begin
        stream_nxt     = data_byte;
        byte_count_nxt = '0;
        phase_nxt      = PH_BUF;
      end
      PH_BUF: begin
        bufsize_nxt    = {cur_bufsize[15:0], data_byte};
        byte_count_nxt = count_inc;
        if (count_inc >= BUF_BYTES) begin
          phase_nxt      = PH_MAX;
          byte_count_nxt = '0;
        end
      end
      PH_MAX: begin
        maxrate_nxt    = {cur_maxrate[23:0], data_byte};
        byte_count_nxt = count_inc;
        if (count_inc >= RATE_BYTES) begin
          phase_nxt      = PH_AVG;
          byte_count_nxt = '0;
        end
      end
      PH_AVG: begin
        avgrate_nxt    = {cur_avgrate[23:0], data_byte};
        byte_count_nxt = count_inc;
        if (count_inc >= RATE_BYTES) begin
          phase_nxt      = PH_TAG3;
          byte_count_nxt = '0;
        end
      end
      PH_TAG3: begin
        if (data_byte != TAG_DSI) begin
          status_s  = ST_ERROR;
          phase_nxt = PH_ERR;
        end else begin
          phase_nxt        = PH_LEN3;
          byte_count_nxt   = '0;
          length_accum_nxt = '0;
        end
      end
      PH_LEN3: begin
        length_accum_nxt = len_shift;
        byte_count_nxt   = count_inc;
        if (len_done) begin
          cfglen_nxt = len_shift;
          if (len_shift == '0) begin
            status_s  = ST_COMPLETE;
            phase_nxt = PH_DONE;
          end else begin
            remaining_nxt = len_shift;
            phase_nxt     = PH_CFG;
          end
        end
      end
      PH_CFG: begin
        cfg_byte_s    = data_byte;
        status_s      = ST_CFG;
        remaining_nxt = rem_dec;
        if (rem_dec == '0) begin
          status_s  = ST_COMPLETE;
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        // idle, done and error: byte is dropped
        status_s = ST_IGNORED;
      end
    endcase
  end

  // Parse state, advanced once per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      byte_count_r   <= '0;
      length_accum_r <= '0;
      remaining_r    <= '0;
      object_r       <= '0;
      stream_r       <= '0;
      bufsize_r      <= '0;
      maxrate_r      <= '0;
      avgrate_r      <= '0;
      cfglen_r       <= '0;
      version_r      <= '0;
      flags_r        <= '0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      length_accum_r <= length_accum_nxt;
      remaining_r    <= remaining_nxt;
      object_r       <= object_nxt;
      stream_r       <= stream_nxt;
      bufsize_r      <= bufsize_nxt;
      maxrate_r      <= maxrate_nxt;
      avgrate_r      <= avgrate_nxt;
      cfglen_r       <= cfglen_nxt;
      version_r      <= version_nxt;
      flags_r        <= flags_nxt;
    end
  end

  // Result carries the register contents after this byte
  always_comb begin
    result.status        = status_s;
    result.config_byte   = cfg_byte_s;
    result.object_type   = object_nxt;
    result.stream_type   = stream_nxt;
    result.buffer_size   = bufsize_nxt;
    result.max_bitrate   = maxrate_nxt;
    result.avg_bitrate   = avgrate_nxt;
    result.config_length = cfglen_nxt;
    result.version       = version_nxt;
    result.flags         = flags_nxt;
  end

endmodule

/* src/es_descriptor_byte_parser_core.sv */
// Channel  Dir  Payload                                         Transfer
// in_ch    in   data_byte[7:0], start_req                       valid && ready
// out_ch   out  status, config_byte, parsed fields, flags       valid && ready
//
// One byte per cycle sustained while out_ch.ready stays high; each byte is registered in
// the input register, decoded by the parse state machine, and the result lands in an
// output register that holds under stall.
// in_ch.ready stays high while the output register is empty or being drained.
// Reset (rst_n low, synchronous) clears both stages and returns the parser to idle.
module es_descriptor_byte_parser_core
  import esdp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  esdp_in_if.sink   in_ch,
  esdp_out_if.source out_ch
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       s1_advance;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    step_res;

  // Stage one moves on when the output register is free or draining
  assign s1_advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r  <= in_ch.data_byte;
      s1_start_r <= in_ch.start_req;
    end
  end

  esdp_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_advance),
    .data_byte (s1_byte_r),
    .start_req (s1_start_r),
    .result    (step_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.config_byte   = out_res_r.config_byte;
  assign out_ch.object_type   = out_res_r.object_type;
  assign out_ch.stream_type   = out_res_r.stream_type;
  assign out_ch.buffer_size   = out_res_r.buffer_size;
  assign out_ch.max_bitrate   = out_res_r.max_bitrate;
  assign out_ch.avg_bitrate   = out_res_r.avg_bitrate;
  assign out_ch.config_length = out_res_r.config_length;
  assign out_ch.version       = out_res_r.version;
  assign out_ch.flags         = out_res_r.flags;

endmodule

/* src/esdp_checker.sv */
`include "es_descriptor_byte_parser_core_defines.svh"

module esdp_checker
  import esdp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [7:0]  config_byte,
  input logic [27:0] config_length
);

  // Stalled status and config byte hold
  `ESDP_ASSERT_STALL(a_stall_status, clk, rst_n, out_valid, out_ready, status)
  `ESDP_ASSERT_STALL(a_stall_cfg_byte, clk, rst_n, out_valid, out_ready, config_byte)

  // Config byte only carries data on config or complete results
  `ESDP_ASSERT_RST(a_cfg_byte_zero, clk, rst_n, (out_valid && (status != ST_CFG) && (status != ST_COMPLETE)) |-> (config_byte == 8'h00), "config byte set outside config output")

  // A config byte is only passed out after a nonzero config length
  `ESDP_ASSERT_RST(a_cfg_len_set, clk, rst_n, (out_valid && (status == ST_CFG)) |-> (config_length != 28'd0), "config byte with zero config length")

endmodule

bind es_descriptor_byte_parser_core esdp_checker u_esdp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .config_byte   (out_ch.config_byte),
  .config_length (out_ch.config_length)
);
